FILE: rtl/core/line_raster_alpha_blend_unit_assert.svh
// assertion macros used by the line raster alpha blend top level
`ifndef LINE_RASTER_ALPHA_BLEND_UNIT_ASSERT_SVH
`define LINE_RASTER_ALPHA_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LRAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LRAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lrab_pkg.sv
// shared types, constants and blend arithmetic for the line raster alpha blend unit
package lrab_pkg;

  // default geometry
  localparam int COORD_WIDTH_DEF   = 14;
  localparam int ADDRESS_WIDTH_DEF = 24;

  // frame dimension registers
  localparam int DIM_W = 13;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // item kinds
  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_STEP  = 1'b1;

  // line colour and blend constants
  localparam logic [7:0] FILL_R    = 8'd255;
  localparam logic [7:0] FILL_G    = 8'd255;
  localparam logic [7:0] FILL_B    = 8'd200;
  localparam logic [7:0] ALPHA_MAX = 8'd255;
  localparam logic [7:0] TOP_BYTE  = 8'hFF;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } lrab_cfg_t;

  typedef struct packed {
    logic write_enable;
    logic read_valid;
    logic line_done;
  } lrab_flags_t;

  // (c*a + s*(255-a)) / 255, the divide done as (v + 1 + (v >> 8)) >> 8
  function automatic logic [7:0] mix(logic [7:0] c, logic [7:0] s, logic [7:0] a);
    logic [15:0] v;
    logic [16:0] t;
    v = 16'({8'd0, c} * {8'd0, a}) + 16'({8'd0, s} * {8'd0, 8'(ALPHA_MAX - a)});
    t = {1'b0, v} + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

FILE: rtl/core/lrab_cfg.sv
// apb frame size registers
module lrab_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrab_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lrab_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lrab_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output lrab_pkg::lrab_cfg_t               cfg_o
);

  logic [lrab_pkg::DIM_W-1:0] width_q, width_d;
  logic [lrab_pkg::DIM_W-1:0] height_q, height_d;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register decode on the word index bit
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      if (paddr[2] == lrab_pkg::REG_IDX_WIDTH) begin
        width_d = pwdata[lrab_pkg::DIM_W-1:0];
      end else begin
        height_d = pwdata[lrab_pkg::DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lrab_pkg::FRAME_WIDTH_RST;
      height_q <= lrab_pkg::FRAME_HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // read back
  assign prdata = (paddr[2] == lrab_pkg::REG_IDX_HEIGHT)
                ? lrab_pkg::CFG_DATA_W'(height_q)
                : lrab_pkg::CFG_DATA_W'(width_q);

  assign cfg_o.frame_width  = width_q;
  assign cfg_o.frame_height = height_q;

endmodule

FILE: rtl/core/lrab_addr.sv
// clip test and pixel index for one coordinate pair
module lrab_addr #(
  parameter int CW = lrab_pkg::COORD_WIDTH_DEF,
  parameter int AW = lrab_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  lrab_pkg::lrab_cfg_t  cfg_i,
  output logic                 on_screen_o,
  output logic [AW-1:0]        addr_o
);

  localparam int DW   = lrab_pkg::DIM_W;
  localparam int CMPW = (CW > DW) ? CW : DW;
  localparam int PW   = CW + DW;
  localparam int MW   = (PW + 1 > AW) ? PW + 1 : AW;

  logic [CMPW:0] x_u, y_u, w_u, h_u;
  logic [PW-1:0] prod;
  logic [MW-1:0] sum;

  // clip against the frame
  assign x_u = {{(CMPW + 1 - CW){1'b0}}, x_i};
  assign y_u = {{(CMPW + 1 - CW){1'b0}}, y_i};
  assign w_u = {{(CMPW + 1 - DW){1'b0}}, cfg_i.frame_width};
  assign h_u = {{(CMPW + 1 - DW){1'b0}}, cfg_i.frame_height};
  assign on_screen_o = !x_i[CW-1] && !y_i[CW-1] && (x_u < w_u) && (y_u < h_u);

  // row times stride plus column, wrapped to the address width
  assign prod   = $unsigned(y_i) * cfg_i.frame_width;
  assign sum    = MW'(prod) + MW'($unsigned(x_i));
  assign addr_o = sum[AW-1:0];

endmodule

FILE: rtl/core/lrab_blend.sv
// per-channel alpha blend of the line colour over the framebuffer word
module lrab_blend (
  input  logic [31:0] dest_i,
  input  logic [7:0]  alpha_i,
  output logic [31:0] pixel_o
);

  logic [7:0] red, green, blue;

  assign red   = lrab_pkg::mix(lrab_pkg::FILL_R, dest_i[23:16], alpha_i);
  assign green = lrab_pkg::mix(lrab_pkg::FILL_G, dest_i[15:8],  alpha_i);
  assign blue  = lrab_pkg::mix(lrab_pkg::FILL_B, dest_i[7:0],   alpha_i);

  assign pixel_o = {lrab_pkg::TOP_BYTE, red, green, blue};

endmodule

FILE: rtl/core/lrab_walker.sv
// bresenham line state, one start or step word per fire
module lrab_walker #(
  parameter int CW = lrab_pkg::COORD_WIDTH_DEF,
  parameter int AW = lrab_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 action_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic [7:0]           line_alpha_i,
  input  logic [31:0]          dest_pixel_i,
  input  lrab_pkg::lrab_cfg_t  cfg_i,
  output lrab_pkg::lrab_flags_t flags_o,
  output logic [AW-1:0]        write_address_o,
  output logic [31:0]          write_data_o,
  output logic [AW-1:0]        read_address_o
);

  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CW-1:0]        span_x_q, span_x_d, span_y_q, span_y_d;
  logic [1:0]           dir_q, dir_d;
  logic signed [CW+1:0] err_q, err_d;
  logic [7:0]           opa_q, opa_d;
  logic                 fin_q, fin_d;

  // start setup
  logic signed [CW:0]   dx_s, dy_s;
  logic [CW-1:0]        span_x_new, span_y_new;
  logic signed [CW+1:0] err_new;

  assign dx_s = $signed({end_x_i[CW-1], end_x_i}) - $signed({start_x_i[CW-1], start_x_i});
  assign dy_s = $signed({end_y_i[CW-1], end_y_i}) - $signed({start_y_i[CW-1], start_y_i});
  assign span_x_new = dx_s[CW] ? CW'(-dx_s) : dx_s[CW-1:0];
  assign span_y_new = dy_s[CW] ? CW'(-dy_s) : dy_s[CW-1:0];
  assign err_new = $signed({2'b00, span_x_new}) - $signed({2'b00, span_y_new});

  // error term update for one step
  logic signed [CW+2:0] e2, sx_ext, sy_ext, err_sum;
  logic                 step_x, step_y, at_end;
  logic signed [CW-1:0] nx, ny;

  assign e2     = $signed({err_q, 1'b0});
  assign sx_ext = $signed({3'b000, span_x_q});
  assign sy_ext = $signed({3'b000, span_y_q});
  assign step_x = e2 > -sy_ext;
  assign step_y = e2 < sx_ext;
  assign err_sum = $signed({err_q[CW+1], err_q})
                 - (step_x ? sy_ext : '0)
                 + (step_y ? sx_ext : '0);
  assign nx = step_x ? (dir_q[0] ? cur_x_q - CW'(1) : cur_x_q + CW'(1)) : cur_x_q;
  assign ny = step_y ? (dir_q[1] ? cur_y_q - CW'(1) : cur_y_q + CW'(1)) : cur_y_q;
  assign at_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  // address of the pixel being blended and of the next one to fetch
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 cur_on, rd_on;
  logic [AW-1:0]        cur_addr, rd_addr;
  logic [31:0]          blended;

  assign rd_x = (action_i == lrab_pkg::ACTION_START) ? start_x_i : nx;
  assign rd_y = (action_i == lrab_pkg::ACTION_START) ? start_y_i : ny;

  lrab_addr #(.CW(CW), .AW(AW)) u_addr_cur (
    .x_i(cur_x_q), .y_i(cur_y_q), .cfg_i(cfg_i),
    .on_screen_o(cur_on), .addr_o(cur_addr)
  );

  lrab_addr #(.CW(CW), .AW(AW)) u_addr_rd (
    .x_i(rd_x), .y_i(rd_y), .cfg_i(cfg_i),
    .on_screen_o(rd_on), .addr_o(rd_addr)
  );

  lrab_blend u_blend (
    .dest_i(dest_pixel_i), .alpha_i(opa_q), .pixel_o(blended)
  );

  // result and next state
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    dir_d    = dir_q;
    err_d    = err_q;
    opa_d    = opa_q;
    fin_d    = fin_q;
    flags_o  = '0;
    write_address_o = '0;
    write_data_o    = '0;
    read_address_o  = '0;
    if (fire_i) begin
      if (action_i == lrab_pkg::ACTION_START) begin
        cur_x_d  = start_x_i;
        cur_y_d  = start_y_i;
        tgt_x_d  = end_x_i;
        tgt_y_d  = end_y_i;
        span_x_d = span_x_new;
        span_y_d = span_y_new;
        dir_d    = {!(start_y_i < end_y_i), !(start_x_i < end_x_i)};
        err_d    = err_new;
        opa_d    = line_alpha_i;
        fin_d    = 1'b0;
        flags_o.read_valid = rd_on;
        read_address_o     = rd_on ? rd_addr : '0;
      end else if (fin_q) begin
        flags_o.line_done = 1'b1;
      end else begin
        if (cur_on) begin
          flags_o.write_enable = 1'b1;
          write_address_o      = cur_addr;
          write_data_o         = blended;
        end
        if (at_end) begin
          fin_d             = 1'b1;
          flags_o.line_done = 1'b1;
        end else begin
          cur_x_d = nx;
          cur_y_d = ny;
          err_d   = err_sum[CW+1:0];
          flags_o.read_valid = rd_on;
          read_address_o     = rd_on ? rd_addr : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      dir_q    <= '0;
      err_q    <= '0;
      opa_q    <= '0;
      fin_q    <= 1'b1;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      dir_q    <= dir_d;
      err_q    <= err_d;
      opa_q    <= opa_d;
      fin_q    <= fin_d;
    end
  end

endmodule

FILE: rtl/core/line_raster_alpha_blend_unit.sv
// top level of the line raster alpha blend unit: word registers, config, line walker
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser action, tdata endpoints/alpha/pixel
//   m_axis    out        tvalid/tready           tuser enables, tlast line_done, tdata
//   apb       in         psel/penable/pready     frame_width @0x0, frame_height @0x4
//
// one word in per cycle unless m_axis stalls, one result word per input word; each word
// passes the input register, then the result register; the line state loop closes
// through the error update, the pixel index multipliers and the blend feed only the result.
// reset empties both word registers and leaves no line in progress; frame size is 640x480.
// a stalled m_axis holds the result and lets one more word into the input register.
// no clearing pass: the block is ready right after reset.

`include "line_raster_alpha_blend_unit_assert.svh"

module line_raster_alpha_blend_unit #(
  parameter int COORD_WIDTH   = lrab_pkg::COORD_WIDTH_DEF,
  parameter int ADDRESS_WIDTH = lrab_pkg::ADDRESS_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // action
  input  logic                            s_axis_tuser,
  // start_x, start_y, end_x, end_y, line_alpha, dest_pixel, zero pad
  input  logic [((4*COORD_WIDTH+40+7)/8)*8-1:0] s_axis_tdata,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // line_done
  output logic                            m_axis_tlast,
  // write_enable, read_valid
  output logic [1:0]                      m_axis_tuser,
  // write_address, write_data, read_address, zero pad
  output logic [((2*ADDRESS_WIDTH+32+7)/8)*8-1:0] m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrab_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lrab_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lrab_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = ADDRESS_WIDTH;
  localparam int IN_W  = ((4*CW + 40 + 7) / 8) * 8;
  localparam int OUT_W = ((2*AW + 32 + 7) / 8) * 8;

  lrab_pkg::lrab_cfg_t cfg;

  lrab_cfg u_cfg (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cfg_o(cfg)
  );

  // input word register
  logic            in_valid_q, in_valid_d;
  logic            in_user_q, in_user_d;
  logic [IN_W-1:0] in_data_q, in_data_d;
  logic            out_valid_q, out_valid_d;
  logic            advance, s_fire, m_fire;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_user_d  = in_user_q;
    in_data_d  = in_data_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
      in_user_d  = s_axis_tuser;
      in_data_d  = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_user_q <= in_user_d;
    in_data_q <= in_data_d;
  end

  // line walker
  lrab_pkg::lrab_flags_t flags;
  logic [AW-1:0]         waddr, raddr;
  logic [31:0]           wdata;

  lrab_walker #(.CW(CW), .AW(AW)) u_walker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .fire_i(advance),
    .action_i(in_user_q),
    .start_x_i($signed(in_data_q[CW-1:0])),
    .start_y_i($signed(in_data_q[2*CW-1:CW])),
    .end_x_i($signed(in_data_q[3*CW-1:2*CW])),
    .end_y_i($signed(in_data_q[4*CW-1:3*CW])),
    .line_alpha_i(in_data_q[4*CW+7:4*CW]),
    .dest_pixel_i(in_data_q[4*CW+39:4*CW+8]),
    .cfg_i(cfg),
    .flags_o(flags),
    .write_address_o(waddr),
    .write_data_o(wdata),
    .read_address_o(raddr)
  );

  // result word register
  lrab_pkg::lrab_flags_t out_flags_q;
  logic [AW-1:0]         out_waddr_q, out_raddr_q;
  logic [31:0]           out_wdata_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_flags_q <= flags;
      out_waddr_q <= waddr;
      out_wdata_q <= wdata;
      out_raddr_q <= raddr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_flags_q.line_done;
  assign m_axis_tuser  = {out_flags_q.read_valid, out_flags_q.write_enable};
  assign m_axis_tdata  = OUT_W'({out_raddr_q, out_wdata_q, out_waddr_q});

  // checks
  `LRAB_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, in_valid_q, "input stalled while empty")
  `LRAB_ASSERT_NXT(a_result_loaded, advance, out_valid_q, "processed word did not reach output")
  `LRAB_ASSERT_IMP(a_no_write_fields_zero, out_valid_q && !out_flags_q.write_enable,
                   out_waddr_q == '0 && out_wdata_q == '0, "write fields set without write")
  `LRAB_ASSERT_IMP(a_write_top_byte, out_valid_q && out_flags_q.write_enable,
                   out_wdata_q[31:24] == lrab_pkg::TOP_BYTE, "blended word lacks top byte")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the line raster alpha blend unit
module testbench;

  localparam int CW = lrab_pkg::COORD_WIDTH_DEF;
  localparam int AW = lrab_pkg::ADDRESS_WIDTH_DEF;
  localparam int S_W = ((4*CW+40+7)/8)*8;
  localparam int M_W = ((2*AW+32+7)/8)*8;
  localparam int COORD_MIN = -(1 << (CW-1));
  localparam int COORD_MAX = (1 << (CW-1)) - 1;
  localparam int CYCLE_LIMIT = 400000;

  // idling modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic          action;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [7:0]    alpha;
    logic [31:0]   dest;
  } raster_item_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          rv;
    logic [AW-1:0] raddr;
    logic          done;
  } pixel_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic             s_axis_tuser = 1'b0;
  logic [S_W-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic             m_axis_tlast;
  logic [1:0]       m_axis_tuser;
  logic [M_W-1:0]   m_axis_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [lrab_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [lrab_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [lrab_pkg::CFG_DATA_W-1:0] prdata;
  logic             pready;

  line_raster_alpha_blend_unit #(
    .COORD_WIDTH  (CW),
    .ADDRESS_WIDTH(AW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  raster_item_t  pending_words[$];
  pixel_result_t expected_pixels[$];
  raster_item_t  bus_item;
  int            idle_mode = IDLE_NONE;
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // shadow of the frame size and the line walker
  logic [12:0]          frame_w = lrab_pkg::FRAME_WIDTH_RST;
  logic [12:0]          frame_h = lrab_pkg::FRAME_HEIGHT_RST;
  logic signed [CW-1:0] walk_x = '0;
  logic signed [CW-1:0] walk_y = '0;
  logic signed [CW-1:0] goal_x = '0;
  logic signed [CW-1:0] goal_y = '0;
  logic [CW-1:0]        run_x = '0;
  logic [CW-1:0]        run_y = '0;
  logic [1:0]           step_dir = '0;
  logic signed [15:0]   bres_err = '0;
  logic [7:0]           blend_alpha = '0;
  logic                 line_idle = 1'b1;

  function automatic bit is_visible(int x, int y);
    return x >= 0 && x < int'(frame_w) && y >= 0 && y < int'(frame_h);
  endfunction

  function automatic logic [AW-1:0] pixel_index(int x, int y);
    longint p;
    p = longint'(y) * longint'(frame_w) + longint'(x);
    return p[AW-1:0];
  endfunction

  function automatic logic [7:0] blend_channel(int c, int s, int a);
    return 8'((c * a + s * (255 - a)) / 255);
  endfunction

  // advance the line walker by one word and give the result it causes
  function automatic pixel_result_t raster_step(raster_item_t it);
    pixel_result_t r;
    int            e2;
    int            dx;
    int            dy;
    bit            fetch;
    r = '0;
    fetch = 1'b0;
    if (it.action == lrab_pkg::ACTION_START) begin
      walk_x = it.sx;
      walk_y = it.sy;
      goal_x = it.ex;
      goal_y = it.ey;
      dx = int'($signed(it.ex)) - int'($signed(it.sx));
      dy = int'($signed(it.ey)) - int'($signed(it.sy));
      run_x = CW'(dx < 0 ? -dx : dx);
      run_y = CW'(dy < 0 ? -dy : dy);
      step_dir = {$signed(it.sy) >= $signed(it.ey), $signed(it.sx) >= $signed(it.ex)};
      bres_err = 16'(int'(run_x) - int'(run_y));
      blend_alpha = it.alpha;
      line_idle = 1'b0;
      fetch = 1'b1;
    end else if (line_idle) begin
      r.done = 1'b1;
    end else begin
      // read-modify-write of the current pixel
      if (is_visible(walk_x, walk_y)) begin
        r.we = 1'b1;
        r.waddr = pixel_index(walk_x, walk_y);
        r.wdata = {8'hFF,
                   blend_channel(255, int'(it.dest[23:16]), int'(blend_alpha)),
                   blend_channel(255, int'(it.dest[15:8]), int'(blend_alpha)),
                   blend_channel(200, int'(it.dest[7:0]), int'(blend_alpha))};
      end
      if (walk_x == goal_x && walk_y == goal_y) begin
        line_idle = 1'b1;
        r.done = 1'b1;
      end else begin
        e2 = 2 * int'(bres_err);
        if (e2 > -int'(run_y)) begin
          bres_err = 16'(int'(bres_err) - int'(run_y));
          walk_x = CW'(int'(walk_x) + (step_dir[0] ? -1 : 1));
        end
        if (e2 < int'(run_x)) begin
          bres_err = 16'(int'(bres_err) + int'(run_x));
          walk_y = CW'(int'(walk_y) + (step_dir[1] ? -1 : 1));
        end
        fetch = 1'b1;
      end
    end
    if (fetch && is_visible(walk_x, walk_y)) begin
      r.rv = 1'b1;
      r.raddr = pixel_index(walk_x, walk_y);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on %0s: got %h, expected %h", what, got, want);
  endtask

  function automatic bit sender_idle();
    int k;
    k = $urandom_range(99);
    return (idle_mode == IDLE_SEND && k < 85) || (idle_mode == IDLE_BOTH && k < 21);
  endfunction

  function automatic bit receiver_stall();
    int k;
    k = $urandom_range(99);
    return (idle_mode == IDLE_RECV && k < 85) || (idle_mode == IDLE_BOTH && k < 21);
  endfunction

  // input word driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(raster_step(bus_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && !sender_idle()) begin
          bus_item = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= bus_item.action;
          s_axis_tdata <= {bus_item.dest, bus_item.alpha, bus_item.ey, bus_item.ex,
                           bus_item.sy, bus_item.sx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result word monitor
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result word with none expected", 32'(m_axis_tdata), 32'h0);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tuser[0] !== want.we)
            report_mismatch("write_enable", 32'(m_axis_tuser[0]), 32'(want.we));
          if (m_axis_tdata[AW-1:0] !== want.waddr)
            report_mismatch("write_address", 32'(m_axis_tdata[AW-1:0]), 32'(want.waddr));
          if (m_axis_tdata[AW+31:AW] !== want.wdata)
            report_mismatch("write_data", m_axis_tdata[AW+31:AW], want.wdata);
          if (m_axis_tuser[1] !== want.rv)
            report_mismatch("read_valid", 32'(m_axis_tuser[1]), 32'(want.rv));
          if (m_axis_tdata[2*AW+31:AW+32] !== want.raddr)
            report_mismatch("read_address", 32'(m_axis_tdata[2*AW+31:AW+32]),
                            32'(want.raddr));
          if (m_axis_tlast !== want.done)
            report_mismatch("line_done", 32'(m_axis_tlast), 32'(want.done));
        end
      end
      m_axis_tready <= !receiver_stall();
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** line_raster_alpha_blend_unit: FAILED **");
      $finish;
    end
  end

  function automatic void queue_start(int sx, int sy, int ex, int ey, int alpha);
    raster_item_t it;
    it.action = lrab_pkg::ACTION_START;
    it.sx = CW'(sx);
    it.sy = CW'(sy);
    it.ex = CW'(ex);
    it.ey = CW'(ey);
    it.alpha = 8'(alpha);
    it.dest = $urandom;
    pending_words.push_back(it);
  endfunction

  // step word, unused start fields carry noise
  function automatic void queue_step(logic [31:0] dest);
    raster_item_t it;
    it.action = lrab_pkg::ACTION_STEP;
    it.sx = CW'($urandom);
    it.sy = CW'($urandom);
    it.ex = CW'($urandom);
    it.ey = CW'($urandom);
    it.alpha = 8'($urandom);
    it.dest = dest;
    pending_words.push_back(it);
  endfunction

  function automatic int clamp_coord(int v);
    return v < COORD_MIN ? COORD_MIN : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  // coordinate near the frame, edges favored
  function automatic int pick_near(int extent);
    int k;
    k = $urandom_range(9);
    if (k < 2) return int'($urandom_range(0, 8)) - 4;
    if (k < 4) return extent - 4 + int'($urandom_range(0, 8));
    return int'($urandom_range(0, extent + 8)) - 4;
  endfunction

  // mostly whole lines with random content, some abandoned lines and stray steps
  task automatic queue_random(int n);
    int kind;
    int sx;
    int sy;
    int ex;
    int ey;
    int reach;
    int span;
    int nsteps;
    int alpha;
    int pushed;
    pushed = 0;
    while (pushed < n) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        nsteps = $urandom_range(1, 3);
        repeat (nsteps) queue_step($urandom);
        pushed += nsteps;
      end else begin
        if (kind < 20) begin
          sx = int'($urandom_range(0, 16383)) + COORD_MIN;
          sy = int'($urandom_range(0, 16383)) + COORD_MIN;
          ex = int'($urandom_range(0, 16383)) + COORD_MIN;
          ey = int'($urandom_range(0, 16383)) + COORD_MIN;
        end else begin
          reach = ($urandom_range(99) < 10) ? 150 : 24;
          sx = clamp_coord(pick_near(int'(frame_w)));
          sy = clamp_coord(pick_near(int'(frame_h)));
          ex = clamp_coord(sx + int'($urandom_range(0, 2*reach)) - reach);
          ey = clamp_coord(sy + int'($urandom_range(0, 2*reach)) - reach);
        end
        case ($urandom_range(4))
          0: alpha = 0;
          1: alpha = 255;
          default: alpha = $urandom_range(255);
        endcase
        queue_start(sx, sy, ex, ey, alpha);
        span = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > span) span = (ey > sy ? ey - sy : sy - ey);
        span = span + 1;
        if (kind < 20 || $urandom_range(99) < 10)
          nsteps = $urandom_range(0, span < 8 ? span : 8);
        else
          nsteps = span + int'($urandom_range(0, 2));
        repeat (nsteps) queue_step($urandom);
        pushed += 1 + nsteps;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, then read back
  task automatic cfg_write(logic [lrab_pkg::CFG_ADDR_W-1:0] addr, logic [12:0] value);
    logic [lrab_pkg::CFG_DATA_W-1:0] got;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == lrab_pkg::REG_IDX_WIDTH) frame_w = value;
    else frame_h = value;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== 32'(value)) report_mismatch("register read back", got, 32'(value));
  endtask

  task automatic run_phase(int w, int h, int mode, int n);
    cfg_write({lrab_pkg::REG_IDX_WIDTH, 2'b00}, 13'(w));
    cfg_write({lrab_pkg::REG_IDX_HEIGHT, 2'b00}, 13'(h));
    @(negedge clk_i);
    idle_mode = mode;
    queue_random(n);
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_mode = IDLE_NONE;
    // step with no line in progress
    queue_step(32'h1234_5678);
    // one-pixel line, then a step past its end
    queue_start(5, 5, 5, 5, 255);
    queue_step(32'h0000_0000);
    queue_step(32'hFFFF_FFFF);
    // full-range diagonals, off screen, abandoned by a new start
    queue_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0);
    queue_step(32'hFFFF_FFFF);
    queue_step(32'h0000_0000);
    queue_start(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1);
    queue_step(32'hA5A5_A5A5);
    // crossing the bottom right corner of the frame
    queue_start(639, 479, 642, 481, 128);
    queue_step(32'hFFFF_FFFF);
    queue_step(32'h00FF_FFFF);
    queue_step(32'hFF00_0000);
    queue_step(32'h0000_0000);
    queue_step(32'h5A5A_5A5A);
    // leaving through the top edge
    queue_start(0, 0, 3, -2, 254);
    queue_step(32'h0080_40C8);
    queue_step(32'hFFFF_FFFF);
    queue_step(32'h0000_0000);
    queue_step(32'h0101_0101);
    // horizontal line toward smaller x, abandoned mid-way
    queue_start(2, 3, 0, 3, 255);
    queue_step(32'h00C8_C8C8);
    queue_start(0, 1, 0, 0, 0);
    queue_step(32'h00FE_FDFC);
    queue_step(32'h0003_0201);
    queue_random(180);
    wait_drained();

    run_phase(1, 1, IDLE_SEND, 120);
    run_phase(4096, 4096, IDLE_RECV, 180);
    run_phase(8191, 8191, IDLE_BOTH, 300);
    run_phase(0, 480, IDLE_NONE, 80);
    run_phase(640, 0, IDLE_SEND, 80);
    run_phase(23, 9, IDLE_RECV, 180);
    run_phase(4096, 1, IDLE_BOTH, 180);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), IDLE_NONE, 150);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), IDLE_BOTH, 150);
    run_phase(640, 480, IDLE_SEND, 150);

    if (mismatch_count == 0)
      $display("** line_raster_alpha_blend_unit: PASSED **");
    else
      $display("** line_raster_alpha_blend_unit: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lrab_pkg.sv
rtl/core/lrab_cfg.sv
rtl/core/lrab_addr.sv
rtl/core/lrab_blend.sv
rtl/core/lrab_walker.sv
rtl/core/line_raster_alpha_blend_unit.sv
verif/testbench.sv
